[design/crf_pkg.sv]
`timescale 1ns / 1ps

package crf_pkg;

	localparam int NUM_FRAMES_DEF = 16;
	localparam int PID_W = 16;

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_EVICT = 2'd1;
	localparam logic [1:0] FUNC_FREE  = 2'd2;

	localparam logic [0:0] STATUS_OK   = 1'b0;
	localparam logic [0:0] STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [1:0]       func;
		logic [PID_W-1:0] pid;
	} crf_in_t;

	typedef struct packed {
		logic [3:0]       frame;
		logic [0:0]       status;
		logic [PID_W-1:0] victim_owner;
		logic [4:0]       frames_used;
	} crf_out_t;

	typedef struct packed {
		logic alloc_wr;
		logic rel;
		logic ref_clr;
	} crf_cmd_t;

endpackage

[design/crf_table.sv]
`timescale 1ns / 1ps

module crf_table #(
	parameter int NUM_FRAMES = crf_pkg::NUM_FRAMES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  crf_pkg::crf_cmd_t                      cmd,
	input  logic [$clog2(NUM_FRAMES)-1:0]          idx,
	input  logic [crf_pkg::PID_W-1:0]              pid,
	output logic                                   used_bit,
	output logic                                   ref_bit,
	output logic [crf_pkg::PID_W-1:0]              rd_data,
	output logic [$clog2(NUM_FRAMES+1)-1:0]        count
);
	import crf_pkg::*;

	localparam int CW = $clog2(NUM_FRAMES + 1);

	logic [PID_W-1:0]      mem_q [NUM_FRAMES];
	logic [PID_W-1:0]      rd_q;
	logic [NUM_FRAMES-1:0] used_q;
	logic [NUM_FRAMES-1:0] ref_q;
	logic [CW-1:0]         count_q;

	assign used_bit = used_q[idx];
	assign ref_bit  = ref_q[idx];
	assign rd_data  = rd_q;
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (cmd.alloc_wr) begin
			mem_q[idx] <= pid;
		end
		rd_q <= mem_q[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			ref_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.alloc_wr) begin
				used_q[idx] <= (pid != '0);
				ref_q[idx]  <= 1'b1;
				if (pid != '0 && !used_q[idx]) begin
					count_q <= count_q + CW'(1);
				end
			end else if (cmd.rel) begin
				used_q[idx] <= 1'b0;
				ref_q[idx]  <= 1'b0;
				if (used_q[idx]) begin
					count_q <= count_q - CW'(1);
				end
			end else if (cmd.ref_clr) begin
				ref_q[idx] <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == 32'(count_q))
		else $error("frame use count disagrees with the owned frames");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= NUM_FRAMES)
		else $error("frame use count exceeds the table size");
	a_rel_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rel && !cmd.alloc_wr && used_q[idx] |=> count_q == $past(count_q) - CW'(1))
		else $error("releasing an owned frame did not lower the count");
`endif

endmodule

[design/crf_ctrl.sv]
`timescale 1ns / 1ps

module crf_ctrl #(
	parameter int NUM_FRAMES = crf_pkg::NUM_FRAMES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  crf_pkg::crf_in_t                       req,
	output logic                                   idle,
	output logic                                   done,
	input  logic                                   take,
	output crf_pkg::crf_out_t                      res,
	output crf_pkg::crf_cmd_t                      cmd,
	output logic [$clog2(NUM_FRAMES)-1:0]          idx,
	output logic [crf_pkg::PID_W-1:0]              pid,
	input  logic                                   used_bit,
	input  logic                                   ref_bit,
	input  logic [crf_pkg::PID_W-1:0]              rd_data,
	input  logic [$clog2(NUM_FRAMES+1)-1:0]        count
);
	import crf_pkg::*;

	localparam int IW = $clog2(NUM_FRAMES);
	localparam logic [IW-1:0] LAST = IW'(NUM_FRAMES - 1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_AL_SCAN = 3'd1;
	localparam logic [2:0] ST_EV_SCAN = 3'd2;
	localparam logic [2:0] ST_EV_READ = 3'd3;
	localparam logic [2:0] ST_FR_READ = 3'd4;
	localparam logic [2:0] ST_FR_CMP  = 3'd5;
	localparam logic [2:0] ST_DONE    = 3'd6;

	logic [2:0]       state_q;
	logic [IW-1:0]    idx_q;
	logic [IW-1:0]    hand_q;
	logic [PID_W-1:0] pid_q;
	logic [3:0]       frame_q;
	logic [0:0]       status_q;
	logic [PID_W-1:0] victim_q;
	logic [PID_W-1:0] owner;
	logic [IW-1:0]    hand_nxt;

	assign idle     = (state_q == ST_IDLE);
	assign done     = (state_q == ST_DONE);
	assign pid      = pid_q;
	assign owner    = used_bit ? rd_data : '0;
	assign hand_nxt = (hand_q == LAST) ? '0 : hand_q + IW'(1);
	assign idx      = (state_q == ST_EV_SCAN || state_q == ST_EV_READ) ? hand_q : idx_q;

	assign res.frame        = frame_q;
	assign res.status       = status_q;
	assign res.victim_owner = victim_q;
	assign res.frames_used  = 5'(count);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_AL_SCAN: cmd.alloc_wr = !used_bit;
			ST_EV_SCAN: cmd.ref_clr  = ref_bit;
			ST_EV_READ: cmd.rel      = 1'b1;
			ST_FR_CMP:  cmd.rel      = (owner == pid_q);
			default:    cmd          = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pid_q <= req.pid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			hand_q   <= '0;
			frame_q  <= '0;
			status_q <= STATUS_OK;
			victim_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q    <= '0;
						frame_q  <= '0;
						status_q <= STATUS_OK;
						victim_q <= '0;
						case (req.func)
							FUNC_ALLOC: state_q <= ST_AL_SCAN;
							FUNC_EVICT: state_q <= ST_EV_SCAN;
							FUNC_FREE:  state_q <= ST_FR_READ;
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_AL_SCAN: begin
					if (!used_bit) begin
						frame_q <= 4'(idx_q);
						state_q <= ST_DONE;
					end else if (idx_q == LAST) begin
						status_q <= STATUS_FULL;
						state_q  <= ST_DONE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_EV_SCAN: begin
					if (ref_bit) begin
						hand_q <= hand_nxt;
					end else begin
						state_q <= ST_EV_READ;
					end
				end
				ST_EV_READ: begin
					victim_q <= owner;
					frame_q  <= 4'(hand_q);
					hand_q   <= hand_nxt;
					state_q  <= ST_DONE;
				end
				ST_FR_READ: begin
					state_q <= ST_FR_CMP;
				end
				ST_FR_CMP: begin
					if (idx_q == LAST) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_FR_READ;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		hand_q <= LAST)
		else $error("clock hand left the frame table");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one table operation in a cycle");
	a_alloc_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_wr |=> state_q == ST_DONE && status_q == STATUS_OK)
		else $error("allocation write did not complete the request");
	a_take_done: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> done)
		else $error("result taken before the request finished");
`endif

endmodule

[design/clock_frame_replacement_top.sv]
`timescale 1ns / 1ps

// Clock (second-chance) frame replacement table with NUM_FRAMES frames.
// Requests arrive on the in channel (in_valid, in_ready, in_data) and one
// result beat per request leaves on the out channel (out_valid, out_ready,
// out_data). Both channels use a valid/ready handshake.
// One request is worked on at a time; in_ready is high only while the
// sequencer is idle. An index counter walks the frame table one frame per
// cycle when allocating, and the clock hand does so when evicting:
//   allocate: scan from frame 0 to the first free frame, or to the last;
//   evict: skip frames given a second chance, then read the victim owner;
//   free: each owner is read from RAM and then compared, frame by frame;
//   unused code: no table access.
// A new request may be accepted in the cycle after the result is loaded.
// The result sits in an output register; while the receiver stalls, a
// finished request waits in the sequencer until the register is free.
// Reset empties the table, clears every reference bit, parks the clock hand
// at frame 0 and drops out_valid; no clearing pass is needed.

module clock_frame_replacement_top #(
	parameter int NUM_FRAMES = crf_pkg::NUM_FRAMES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  crf_pkg::crf_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output crf_pkg::crf_out_t out_data
);
	import crf_pkg::*;

	localparam int IW = $clog2(NUM_FRAMES);
	localparam int CW = $clog2(NUM_FRAMES + 1);

	logic             idle;
	logic             done;
	logic             take;
	logic             start;
	crf_out_t         res;
	crf_cmd_t         cmd;
	logic [IW-1:0]    idx;
	logic [PID_W-1:0] pid;
	logic             used_bit;
	logic             ref_bit;
	logic [PID_W-1:0] rd_data;
	logic [CW-1:0]    count;
	logic             out_valid_q;
	crf_out_t         out_data_q;

	assign in_ready  = idle;
	assign start     = in_valid && idle;
	assign take      = done && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	crf_ctrl #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (in_data),
		.idle     (idle),
		.done     (done),
		.take     (take),
		.res      (res),
		.cmd      (cmd),
		.idx      (idx),
		.pid      (pid),
		.used_bit (used_bit),
		.ref_bit  (ref_bit),
		.rd_data  (rd_data),
		.count    (count)
	);

	crf_table #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.idx      (idx),
		.pid      (pid),
		.used_bit (used_bit),
		.ref_bit  (ref_bit),
		.rd_data  (rd_data),
		.count    (count)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in progress");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid)
		else $error("finished request did not reach the output register");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("stalled result beat was overwritten");
`endif

endmodule
